### src/pida_pkg.sv
package pida_pkg;

    localparam int DEFAULT_CAPACITY = 8;
    localparam int POS_W            = 4;
    localparam int VAL_W            = 32;
    localparam int CNT_W            = 4;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_INS_REJECT = 2'd1,
        ST_DEL_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       op;
        logic [POS_W-1:0]          position;
        logic signed [VAL_W-1:0]   value;
    } t_in_word;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   element;
        logic [CNT_W-1:0]          count;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic execute;
    } t_dp_cmd;

endpackage

### src/pida_ctrl.sv
module pida_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output pida_pkg::t_dp_cmd o_cmd
);

    pida_pkg::t_ctrl_state r_state;
    pida_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pida_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pida_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pida_pkg::S_EXEC;
                end
            end
            pida_pkg::S_EXEC: begin
                n_state = pida_pkg::S_OUT;
            end
            pida_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_state = pida_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pida_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_out_valid   = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            pida_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            pida_pkg::S_EXEC: begin
                o_cmd.execute = 1'b1;
            end
            pida_pkg::S_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

### src/pida_datapath.sv
module pida_datapath #(
    parameter int CAPACITY = pida_pkg::DEFAULT_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pida_pkg::t_dp_cmd   i_cmd,
    input  pida_pkg::t_in_word  i_in_word,
    output pida_pkg::t_out_word o_out_word
);

    localparam int CW = $clog2(CAPACITY + 1);
    // Common width for comparing positions with the count.
    localparam int IW = (CW > pida_pkg::POS_W) ? CW : pida_pkg::POS_W;

    pida_pkg::t_in_word            r_item;
    logic [CW-1:0]                 r_used;
    logic [CW-1:0]                 n_used;
    logic signed [pida_pkg::VAL_W-1:0] r_entries [CAPACITY];
    logic signed [pida_pkg::VAL_W-1:0] n_entries [CAPACITY];
    pida_pkg::t_out_word           r_result;
    pida_pkg::t_out_word           n_result;

    logic [IW-1:0]                 pos_ext;
    logic [IW-1:0]                 used_ext;
    logic                          ins_ok;
    logic                          rd_ok;
    logic signed [pida_pkg::VAL_W-1:0] rd_word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.execute) begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_entries <= n_entries;
            r_result  <= n_result;
        end
    end

    assign pos_ext  = IW'(r_item.position);
    assign used_ext = IW'(r_used);
    assign ins_ok   = (r_used < CW'(CAPACITY)) && (pos_ext <= used_ext);
    assign rd_ok    = (pos_ext < used_ext);

    always_comb begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (IW'(k) == pos_ext) begin
                rd_word = r_entries[k];
            end
        end
    end

    always_comb begin
        n_entries        = r_entries;
        n_used           = r_used;
        n_result.status  = pida_pkg::ST_DONE;
        n_result.element = '0;
        case (r_item.op)
            pida_pkg::OP_CLEAR: begin
                n_used = '0;
            end
            pida_pkg::OP_INSERT: begin
                if (ins_ok) begin
                    // Entries from the position up to the old end move up by one.
                    for (int k = 1; k < CAPACITY; k++) begin
                        if (IW'(k) > pos_ext && IW'(k) <= used_ext) begin
                            n_entries[k] = r_entries[k-1];
                        end
                    end
                    for (int k = 0; k < CAPACITY; k++) begin
                        if (IW'(k) == pos_ext) begin
                            n_entries[k] = r_item.value;
                        end
                    end
                    n_used = r_used + CW'(1);
                end else begin
                    n_result.status = pida_pkg::ST_INS_REJECT;
                end
            end
            pida_pkg::OP_DELETE, pida_pkg::OP_READ: begin
                if (rd_ok) begin
                    n_result.element = rd_word;
                    if (r_item.op == pida_pkg::OP_DELETE) begin
                        for (int k = 0; k < CAPACITY - 1; k++) begin
                            if (IW'(k) >= pos_ext && IW'(k + 1) < used_ext) begin
                                n_entries[k] = r_entries[k+1];
                            end
                        end
                        n_used = r_used - CW'(1);
                    end
                end else begin
                    n_result.status = pida_pkg::ST_DEL_REJECT;
                end
            end
            default: begin
                n_used = r_used;
            end
        endcase
        n_result.count = pida_pkg::CNT_W'(n_used);
    end

    assign o_out_word = r_result;

endmodule

### src/positional_insert_delete_array_top.sv
// An accepted word is registered, executed in the EXEC state, and its result is
// registered and offered in the OUT state until the output takes it.
// The controller steps through its accept, execute and deliver states in turn, so
// only one word is in flight; new input stalls until the result has been taken.
// Reset (synchronous, active low) empties the list and idles the controller;
// list entries are not cleared and are only read after being written.
module positional_insert_delete_array_top #(
    parameter int CAPACITY = pida_pkg::DEFAULT_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pida_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pida_pkg::t_out_word o_out_word
);

    pida_pkg::t_dp_cmd cmd;

    pida_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    pida_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

### src/pida_checker.sv
module pida_checker #(
    parameter int CAPACITY = pida_pkg::DEFAULT_CAPACITY
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input pida_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pida_pkg::t_out_word o_out_word
);

    // A word is never accepted while a result is still on offer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    // An accepted word goes through the execute state before its result appears.
    a_exec_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result appeared without an execute cycle");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status != pida_pkg::ST_DONE)
            |-> (o_out_word.element == '0))
        else $error("rejected operation returned a nonzero element");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.count <= CAPACITY))
        else $error("count exceeds capacity");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

endmodule

bind positional_insert_delete_array_top pida_checker #(
    .CAPACITY (CAPACITY)
) u_pida_checker (.*);

### dv/positional_insert_delete_array_top_tb.sv
`timescale 1ns / 1ps

module positional_insert_delete_array_top_tb;

    localparam int CAP          = pida_pkg::DEFAULT_CAPACITY;
    localparam int POS_W        = pida_pkg::POS_W;
    localparam int VAL_W        = pida_pkg::VAL_W;
    localparam int CNT_W        = pida_pkg::CNT_W;
    localparam int N_RANDOM     = 1826;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        pida_pkg::t_in_word  cmd;
        logic                typed;
        pida_pkg::t_out_word exp;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    pida_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    pida_pkg::t_out_word o_out_word;

    positional_insert_delete_array_top #(
        .CAPACITY(CAP)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // Shadow copy of the list, updated in acceptance order.
    logic signed [VAL_W-1:0] shadow_list [CAP];
    int                      shadow_len;

    pida_pkg::t_out_word awaited_out_words [$];
    t_stim_row           directed_rows [$];
    int                  n_errors;
    int                  n_accepted;
    int                  cycle_cnt;
    int                  in_burst_left;
    int                  load_left;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic pida_pkg::t_out_word apply_list_op(pida_pkg::t_in_word w);
        pida_pkg::t_out_word r;
        int                  k;
        r.status  = pida_pkg::ST_DONE;
        r.element = '0;
        case (w.op)
            pida_pkg::OP_CLEAR: begin
                shadow_len = 0;
            end
            pida_pkg::OP_INSERT: begin
                if (shadow_len >= CAP || int'(w.position) > shadow_len) begin
                    r.status = pida_pkg::ST_INS_REJECT;
                end else begin
                    for (k = shadow_len; k > int'(w.position); k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[w.position] = w.value;
                    shadow_len++;
                end
            end
            default: begin
                if (int'(w.position) >= shadow_len) begin
                    r.status = pida_pkg::ST_DEL_REJECT;
                end else begin
                    r.element = shadow_list[w.position];
                    if (w.op == pida_pkg::OP_DELETE) begin
                        for (k = int'(w.position); k + 1 < shadow_len; k++)
                            shadow_list[k] = shadow_list[k+1];
                        shadow_len--;
                    end
                end
            end
        endcase
        r.count = CNT_W'(shadow_len);
        return r;
    endfunction

    task automatic add_row(pida_pkg::t_op op, int pos, logic [VAL_W-1:0] val,
                           logic typed, pida_pkg::t_status st,
                           logic [VAL_W-1:0] el, int cnt);
        t_stim_row row;
        row.cmd.op       = op;
        row.cmd.position = POS_W'(pos);
        row.cmd.value    = val;
        row.typed        = typed;
        row.exp.status   = st;
        row.exp.element  = el;
        row.exp.count    = CNT_W'(cnt);
        directed_rows.push_back(row);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed traffic against the current list, with some
    // out-of-range positions and whole-list loads mixed in.
    function automatic pida_pkg::t_in_word pick_random_word();
        pida_pkg::t_in_word w;
        int                 r;
        w.value = pick_value();
        if (load_left > 0) begin
            load_left--;
            w.op       = pida_pkg::OP_INSERT;
            w.position = POS_W'(shadow_len);
            return w;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            w.op       = pida_pkg::OP_CLEAR;
            w.position = POS_W'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1)
                load_left = $urandom_range(1, CAP + 1);
            return w;
        end
        if (r < 45 || (shadow_len < 2 && r < 70))
            w.op = pida_pkg::OP_INSERT;
        else if (r < 68)
            w.op = pida_pkg::OP_DELETE;
        else
            w.op = pida_pkg::OP_READ;
        r = $urandom_range(0, 99);
        if (r < 15)
            w.position = POS_W'($urandom_range(0, 15));
        else if (w.op == pida_pkg::OP_INSERT)
            w.position = POS_W'($urandom_range(0, shadow_len));
        else if (shadow_len > 0)
            w.position = POS_W'($urandom_range(0, shadow_len - 1));
        else
            w.position = POS_W'($urandom_range(0, 15));
        return w;
    endfunction

    task automatic drive_word(pida_pkg::t_in_word cmd, logic typed,
                              pida_pkg::t_out_word exp);
        pida_pkg::t_out_word predicted;
        i_in_valid <= 1'b1;
        i_in_word  <= cmd;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        // The word is taken at this edge.
        predicted = apply_list_op(cmd);
        awaited_out_words.push_back(typed ? exp : predicted);
        n_accepted++;
    endtask

    task automatic sender_gap();
        int gap;
        int r;
        gap = 0;
        if (in_burst_left > 0) begin
            in_burst_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3)
                in_burst_left = $urandom_range(20, 80);
            else if (r < 50)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_word     = '0;
        n_errors      = 0;
        n_accepted    = 0;
        in_burst_left = 0;
        load_left     = 0;
        shadow_len    = 0;

        add_row(pida_pkg::OP_READ, 0, 32'h0, 1, pida_pkg::ST_DEL_REJECT, 32'h0, 0);
        add_row(pida_pkg::OP_DELETE, 0, 32'h1234_5678, 1, pida_pkg::ST_DEL_REJECT,
                32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 1, 32'h1, 1, pida_pkg::ST_INS_REJECT, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 0, 32'h7FFF_FFFF, 1, pida_pkg::ST_DONE, 32'h0, 1);
        add_row(pida_pkg::OP_INSERT, 1, 32'h8000_0000, 1, pida_pkg::ST_DONE, 32'h0, 2);
        add_row(pida_pkg::OP_READ, 0, 32'h0, 1, pida_pkg::ST_DONE, 32'h7FFF_FFFF, 2);
        add_row(pida_pkg::OP_READ, 1, 32'hFFFF_FFFF, 1, pida_pkg::ST_DONE,
                32'h8000_0000, 2);
        add_row(pida_pkg::OP_INSERT, 0, 32'hFFFF_FFFF, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 3, 32'h0, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 2, 32'h1, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 5, 32'h5A5A_5A5A, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 1, 32'hA5A5_A5A5, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 7, 32'd123, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 0, 32'd9, 1, pida_pkg::ST_INS_REJECT, 32'h0, CAP);
        add_row(pida_pkg::OP_READ, 8, 32'h0, 1, pida_pkg::ST_DEL_REJECT, 32'h0, CAP);
        add_row(pida_pkg::OP_READ, 15, 32'h0, 1, pida_pkg::ST_DEL_REJECT, 32'h0, CAP);
        add_row(pida_pkg::OP_DELETE, 7, 32'h0, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_DELETE, 0, 32'h0, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_READ, 3, 32'h0, 0, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_CLEAR, 15, 32'hFFFF_FFFF, 1, pida_pkg::ST_DONE, 32'h0, 0);
        add_row(pida_pkg::OP_READ, 0, 32'h0, 1, pida_pkg::ST_DEL_REJECT, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 15, 32'h0, 1, pida_pkg::ST_INS_REJECT, 32'h0, 0);
        add_row(pida_pkg::OP_INSERT, 0, 32'd42, 1, pida_pkg::ST_DONE, 32'h0, 1);
        add_row(pida_pkg::OP_DELETE, 0, 32'h0, 1, pida_pkg::ST_DONE, 32'd42, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            drive_word(directed_rows[i].cmd, directed_rows[i].typed,
                       directed_rows[i].exp);
            sender_gap();
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            drive_word(pick_random_word(), 1'b0, '0);
            sender_gap();
        end
        i_in_valid <= 1'b0;

        while (awaited_out_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("[positional_insert_delete_array_top] OK");
        else
            $display("[positional_insert_delete_array_top] ERROR");
        $finish;
    end

    // Output back-pressure, with one long hold-off once traffic is flowing.
    initial begin
        int  r;
        int  len;
        logic held_off;
        held_off    = 1'b0;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held_off && n_accepted >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                i_out_stall <= 1'b0;
                len = $urandom_range(50, 200);
            end else if (r < 55) begin
                i_out_stall <= 1'b0;
                len = $urandom_range(1, 4);
            end else if (r < 85) begin
                i_out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else if (r < 97) begin
                i_out_stall <= 1'b1;
                len = $urandom_range(4, 10);
            end else begin
                i_out_stall <= 1'b1;
                len = $urandom_range(20, 60);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        pida_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_out_words.size() == 0) begin
                $error("unexpected output word: status %0d element %0d count %0d",
                       o_out_word.status, o_out_word.element, o_out_word.count);
                n_errors++;
            end else begin
                want = awaited_out_words.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, o_out_word.status);
                    n_errors++;
                end
                if (o_out_word.element !== want.element) begin
                    $error("element mismatch: expected %0d, got %0d",
                           want.element, o_out_word.element);
                    n_errors++;
                end
                if (o_out_word.count !== want.count) begin
                    $error("count mismatch: expected %0d, got %0d",
                           want.count, o_out_word.count);
                    n_errors++;
                end
            end
        end
    end

    initial cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[positional_insert_delete_array_top] ERROR");
            $finish;
        end
    end

endmodule
